// ----- rtl/ffl_pkg.sv -----
// Shared constants, codes, result type and CRC step for the flash file loader.
package ffl_pkg;

  // Flash geometry
  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned FLASH_BYTES  = 8388608;
  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam logic [31:0] FLASH_LIMIT = 32'(FLASH_BYTES);
  localparam logic [8:0]  PAGE_FULL   = 9'(PAGE_BYTES);
  localparam logic [24:0] SECTOR_ROUND = 25'(SECTOR_BYTES - 1);

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Input event codes
  localparam logic [2:0] OP_PING      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_VERIFY    = 3'd2;
  localparam logic [2:0] OP_UNKNOWN   = 3'd3;
  localparam logic [2:0] OP_DATA      = 3'd4;
  localparam logic [2:0] OP_ERASE_DONE = 3'd5;
  localparam logic [2:0] OP_PROG_DONE = 3'd6;
  localparam logic [2:0] OP_READ_BYTE = 3'd7;

  // Result codes
  typedef enum logic [3:0] {
    CODE_NONE        = 4'd0,
    CODE_PONG        = 4'd1,
    CODE_ERR         = 4'd2,
    CODE_READY       = 4'd3,
    CODE_OK_COUNT    = 4'd4,
    CODE_OK_CRC      = 4'd5,
    CODE_ERASE_REQ   = 4'd6,
    CODE_READ_REQ    = 4'd7,
    CODE_BYTE_STORED = 4'd8,
    CODE_PAGE_COMMIT = 4'd9,
    CODE_DROPPED     = 4'd10
  } code_t;

  // One result beat
  typedef struct packed {
    code_t       code;
    logic [22:0] flash_address;
    logic [23:0] request_length;
    logic [7:0]  stored_byte;
    logic [7:0]  page_offset;
    logic [31:0] reply_value;
  } result_t;

  // Fold one byte into the running CRC, one bit per step
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/ffl_ctrl.sv -----
// Loader state machine: decodes one event per beat and forms its result.
module ffl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [2:0]        opcode,
  input  logic [31:0]       file_size,
  input  logic [7:0]        byte_value,
  input  logic              failed,
  output ffl_pkg::result_t  res
);

  typedef enum logic [2:0] {
    MD_IDLE   = 3'd0,
    MD_ERASE  = 3'd1,
    MD_READY  = 3'd2,
    MD_RECV   = 3'd3,
    MD_PROG   = 3'd4,
    MD_VERIFY = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [23:0] size_expected, size_expected_next;
  logic [23:0] bytes_received, bytes_received_next;
  logic [22:0] write_address, write_address_next;
  logic [11:0] sectors_needed, sectors_needed_next;
  logic [11:0] sector_number, sector_number_next;
  logic [8:0]  page_fill, page_fill_next;
  logic [23:0] verify_count, verify_count_next;
  logic [31:0] crc_register, crc_register_next;

  logic [24:0] size_round;
  logic [8:0]  fill_inc;
  logic [23:0] recv_inc;
  logic [11:0] sector_inc;
  logic [23:0] verify_inc;
  logic [31:0] crc_step;

  // Increments and the sector count of a write
  assign size_round = {1'b0, file_size[23:0]} + ffl_pkg::SECTOR_ROUND;
  assign fill_inc   = page_fill + 9'd1;
  assign recv_inc   = bytes_received + 24'd1;
  assign sector_inc = sector_number + 12'd1;
  assign verify_inc = verify_count + 24'd1;
  assign crc_step   = ffl_pkg::crc32_byte(crc_register, byte_value);

  // Decode the event against the current mode
  always_comb begin
    mode_next           = mode;
    size_expected_next  = size_expected;
    bytes_received_next = bytes_received;
    write_address_next  = write_address;
    sectors_needed_next = sectors_needed;
    sector_number_next  = sector_number;
    page_fill_next      = page_fill;
    verify_count_next   = verify_count;
    crc_register_next   = crc_register;
    res                 = '0;
    res.code            = ffl_pkg::CODE_NONE;

    if (opcode <= ffl_pkg::OP_UNKNOWN && mode != MD_IDLE) begin
      res.code = ffl_pkg::CODE_DROPPED;
    end else begin
      unique case (opcode)
        ffl_pkg::OP_PING: begin
          res.code = ffl_pkg::CODE_PONG;
        end
        ffl_pkg::OP_WRITE: begin
          if (file_size == 32'd0 || file_size > ffl_pkg::FLASH_LIMIT) begin
            res.code = ffl_pkg::CODE_ERR;
          end else begin
            size_expected_next  = file_size[23:0];
            sectors_needed_next = 12'(size_round >> ffl_pkg::SECTOR_SHIFT);
            sector_number_next  = '0;
            bytes_received_next = '0;
            page_fill_next      = '0;
            write_address_next  = '0;
            mode_next           = MD_ERASE;
            res.code            = ffl_pkg::CODE_ERASE_REQ;
          end
        end
        ffl_pkg::OP_VERIFY: begin
          verify_count_next = '0;
          crc_register_next = ffl_pkg::CRC_INIT;
          if (size_expected == 24'd0) begin
            res.code        = ffl_pkg::CODE_OK_CRC;
            res.reply_value = ~ffl_pkg::CRC_INIT;
          end else begin
            mode_next          = MD_VERIFY;
            res.code           = ffl_pkg::CODE_READ_REQ;
            res.request_length = size_expected;
          end
        end
        ffl_pkg::OP_UNKNOWN: begin
          res.code = ffl_pkg::CODE_ERR;
        end
        ffl_pkg::OP_DATA: begin
          if (mode != MD_READY && mode != MD_RECV) begin
            res.code = ffl_pkg::CODE_DROPPED;
          end else begin
            page_fill_next      = fill_inc;
            bytes_received_next = recv_inc;
            res.stored_byte     = byte_value;
            res.page_offset     = page_fill[7:0];
            // commit on a full page or on the last file byte
            if (fill_inc >= ffl_pkg::PAGE_FULL || recv_inc >= size_expected) begin
              mode_next          = MD_PROG;
              res.code           = ffl_pkg::CODE_PAGE_COMMIT;
              res.flash_address  = write_address;
              res.request_length = {15'd0, fill_inc};
            end else begin
              mode_next = MD_RECV;
              res.code  = ffl_pkg::CODE_BYTE_STORED;
            end
          end
        end
        ffl_pkg::OP_ERASE_DONE: begin
          if (mode != MD_ERASE) begin
            res.code = ffl_pkg::CODE_DROPPED;
          end else if (failed) begin
            mode_next = MD_IDLE;
            res.code  = ffl_pkg::CODE_ERR;
          end else begin
            sector_number_next = sector_inc;
            if (sector_inc >= sectors_needed) begin
              mode_next = MD_READY;
              res.code  = ffl_pkg::CODE_READY;
            end else begin
              res.code          = ffl_pkg::CODE_ERASE_REQ;
              res.flash_address = 23'({sector_inc, {ffl_pkg::SECTOR_SHIFT{1'b0}}});
            end
          end
        end
        ffl_pkg::OP_PROG_DONE: begin
          if (mode != MD_PROG) begin
            res.code = ffl_pkg::CODE_DROPPED;
          end else if (failed) begin
            mode_next = MD_IDLE;
            res.code  = ffl_pkg::CODE_ERR;
          end else begin
            write_address_next = write_address + {14'd0, page_fill};
            page_fill_next     = '0;
            if (bytes_received >= size_expected) begin
              mode_next       = MD_IDLE;
              res.code        = ffl_pkg::CODE_OK_COUNT;
              res.reply_value = {8'd0, bytes_received};
            end else begin
              mode_next = MD_RECV;
            end
          end
        end
        ffl_pkg::OP_READ_BYTE: begin
          if (mode != MD_VERIFY) begin
            res.code = ffl_pkg::CODE_DROPPED;
          end else begin
            crc_register_next = crc_step;
            verify_count_next = verify_inc;
            if (verify_inc >= size_expected) begin
              mode_next       = MD_IDLE;
              res.code        = ffl_pkg::CODE_OK_CRC;
              res.reply_value = ~crc_step;
            end
          end
        end
        default: begin
          res.code = ffl_pkg::CODE_DROPPED;
        end
      endcase
    end
  end

  // Hold state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MD_IDLE;
      size_expected  <= '0;
      bytes_received <= '0;
      write_address  <= '0;
      sectors_needed <= '0;
      sector_number  <= '0;
      page_fill      <= '0;
      verify_count   <= '0;
      crc_register   <= ffl_pkg::CRC_INIT;
    end else if (step) begin
      mode           <= mode_next;
      size_expected  <= size_expected_next;
      bytes_received <= bytes_received_next;
      write_address  <= write_address_next;
      sectors_needed <= sectors_needed_next;
      sector_number  <= sector_number_next;
      page_fill      <= page_fill_next;
      verify_count   <= verify_count_next;
      crc_register   <= crc_register_next;
    end
  end

endmodule

// ----- rtl/flash_file_loader_controller_top.sv -----
// Top level of the flash file loader: event channel, controller and result buffer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per beat: a parsed
//   host command, a file data byte, an erase or program completion, or a
//   byte read back from the flash. Output channel (out_valid / out_stall)
//   returns exactly one result beat per event, in order.
//   Each accepted event's result is registered in the main register, or in the
//   skid register while the main one is full. Throughput: one event per cycle
//   while in_stall is low; decode, counters and CRC byte fold all act on accept.
//   The result side has a main register and a skid register, so events keep
//   flowing while one result waits; in_stall rises only when both hold a
//   result, and it is a registered signal.
//   Reset (rst, synchronous) returns the controller to idle with all counters
//   cleared and the CRC at all ones, and empties the result buffer.
//   When the receiver stalls, the presented result holds until taken.
module flash_file_loader_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] file_size,
  input  logic [7:0]  byte_value,
  input  logic        failed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  code,
  output logic [22:0] flash_address,
  output logic [23:0] request_length,
  output logic [7:0]  stored_byte,
  output logic [7:0]  page_offset,
  output logic [31:0] reply_value
);

  ffl_pkg::result_t res;
  ffl_pkg::result_t main_res;
  ffl_pkg::result_t skid_res;
  logic             skid_valid;
  logic             accept;
  logic             take;
  logic             main_free;

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign take      = out_valid && !out_stall;
  assign main_free = !out_valid || take;

  ffl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .opcode     (opcode),
    .file_size  (file_size),
    .byte_value (byte_value),
    .failed     (failed),
    .res        (res)
  );

  // Track occupancy of the main and skid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Move result payloads: skid drains first, new beats fill the free slot
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        main_res <= skid_res;
      end else if (accept) begin
        main_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign code           = main_res.code;
  assign flash_address  = main_res.flash_address;
  assign request_length = main_res.request_length;
  assign stored_byte    = main_res.stored_byte;
  assign page_offset    = main_res.page_offset;
  assign reply_value    = main_res.reply_value;

endmodule
